@@ hdl/ecp_pkg.sv @@
// ----------------------------------------------------------------------------
// ecp_pkg
// Shared types and constants of the event counter pool.
// ----------------------------------------------------------------------------
package ecp_pkg;

	// pool geometry
	localparam int SLOTS   = 32;
	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_W  = 5;
	localparam int CNT_W   = 64;
	localparam int REF_W   = 16;

	localparam logic [REF_W-1:0] REF_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// item widths
	localparam int IN_W  = 3 + SLOT_W + CNT_W;
	localparam int OUT_W = 2 + SLOT_W + CNT_W + 2;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		CMD_ALLOC   = 3'd0,
		CMD_ACQUIRE = 3'd1,
		CMD_RELEASE = 3'd2,
		CMD_READ    = 3'd3,
		CMD_WRITE   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_INVALID     = 2'd1,
		ST_WOULD_BLOCK = 2'd2,
		ST_NO_SPACE    = 2'd3
	} status_t;

	// one table entry
	typedef struct packed {
		logic [REF_W-1:0] refs;
		logic [CNT_W-1:0] count;
	} entry_t;

endpackage

@@ hdl/event_counter_pool.sv @@
// An accepted item is held in stage 1 with its table read data; its result
// is registered in the output register once that register is free or being
// drained, so m_tvalid waits while an earlier result is still held.
// A new item is accepted only after stage 1 has handed on its item: s_tready
// stays low from the counter table read until the table write-back.
// Reset: arst_n clears the in-use bitmap and all handshake state; counter
// table entries are not reset and are used only once alloc has written them.
// ----------------------------------------------------------------------------
// event_counter_pool
// Pool of event counters with alloc, acquire, release, read and write.
// ----------------------------------------------------------------------------
module event_counter_pool (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// cmd[2:0], slot[7:3], value[71:8]
	input  logic [ecp_pkg::IN_TW-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[1:0], slot_out[6:2], read_value[70:7], readable[71], writable[72]
	output logic [ecp_pkg::OUT_TW-1:0] m_tdata
);
	import ecp_pkg::*;

	// counter table and in-use bitmap
	entry_t             table_mem [SLOTS];
	logic [SLOTS-1:0]   slot_used_q;

	// stage 1: accepted item and table read data
	logic               busy_s1;
	logic [2:0]         cmd_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [CNT_W-1:0]   value_s1;
	entry_t             entry_s1;

	// output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               in_fire;
	logic               step_fire;
	logic [SLOT_AW-1:0] in_idx;
	logic [SLOT_AW-1:0] cur_idx;
	logic [SLOT_AW-1:0] free_idx;
	logic               pool_full;
	logic               slot_ok;
	logic               cur_used;

	// step results
	status_t            st_d;
	logic [SLOT_W-1:0]  slot_out_d;
	logic [CNT_W-1:0]   rd_d;
	logic               readable_d;
	logic               writable_d;
	logic               wr_en_d;
	logic [SLOT_AW-1:0] wr_idx_d;
	entry_t             wr_entry_d;
	logic               used_set_d;
	logic               used_clr_d;
	logic               used_new;
	logic [CNT_W-1:0]   count_new;
	logic [REF_W-1:0]   ref_dec;

	assign in_fire   = s_tvalid && s_tready;
	assign s_tready  = !busy_s1;
	assign step_fire = busy_s1 && (!out_valid_q || m_tready);
	assign in_idx    = SLOT_AW'(s_tdata[3 +: SLOT_W]);
	assign cur_idx   = SLOT_AW'(slot_s1);
	assign slot_ok   = 32'(slot_s1) < 32'(SLOTS);
	assign cur_used  = slot_ok && slot_used_q[cur_idx];

	// lowest free slot
	always_comb begin
		free_idx  = '0;
		pool_full = 1'b1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_idx  = SLOT_AW'(i);
				pool_full = 1'b0;
			end
		end
	end

	// command evaluation on the read entry
	always_comb begin
		st_d       = ST_OK;
		slot_out_d = slot_s1;
		rd_d       = '0;
		wr_en_d    = 1'b0;
		wr_idx_d   = cur_idx;
		wr_entry_d = entry_s1;
		used_set_d = 1'b0;
		used_clr_d = 1'b0;
		used_new   = cur_used;
		count_new  = entry_s1.count;
		ref_dec    = (entry_s1.refs != '0) ? entry_s1.refs - 1'b1 : '0;
		if (cmd_s1 == CMD_ALLOC) begin
			if (pool_full) begin
				st_d       = ST_NO_SPACE;
				slot_out_d = '0;
				used_new   = 1'b0;
			end else begin
				wr_en_d          = 1'b1;
				wr_idx_d         = free_idx;
				wr_entry_d.refs  = REF_W'(1);
				wr_entry_d.count = {32'd0, value_s1[31:0]};
				used_set_d       = 1'b1;
				used_new         = 1'b1;
				count_new        = wr_entry_d.count;
				slot_out_d       = SLOT_W'(free_idx);
			end
		end else if (cmd_s1 > CMD_WRITE) begin
			st_d = ST_INVALID;
		end else if (!cur_used) begin
			st_d = ST_INVALID;
		end else begin
			case (cmd_s1)
				CMD_ACQUIRE: begin
					if (entry_s1.refs != REF_MAX) begin
						wr_en_d         = 1'b1;
						wr_entry_d.refs = entry_s1.refs + 1'b1;
					end
				end
				CMD_RELEASE: begin
					wr_en_d         = 1'b1;
					wr_entry_d.refs = ref_dec;
					if (ref_dec == '0) begin
						wr_entry_d.count = '0;
						used_clr_d       = 1'b1;
						used_new         = 1'b0;
						count_new        = '0;
					end
				end
				CMD_READ: begin
					if (entry_s1.count == '0) begin
						st_d = ST_WOULD_BLOCK;
					end else begin
						rd_d             = entry_s1.count;
						wr_en_d          = 1'b1;
						wr_entry_d.count = '0;
						count_new        = '0;
					end
				end
				default: begin
					// write: reject all ones, block on overflow
					if (value_s1 == CNT_MAX) begin
						st_d = ST_INVALID;
					end else if (entry_s1.count > ~value_s1) begin
						st_d = ST_WOULD_BLOCK;
					end else begin
						wr_en_d          = 1'b1;
						wr_entry_d.count = entry_s1.count + value_s1;
						count_new        = wr_entry_d.count;
					end
				end
			endcase
		end
		readable_d = used_new && (count_new != '0);
		writable_d = used_new && (count_new != CNT_MAX);
	end

	// table read on acceptance, write-back on step
	always_ff @(posedge clk) begin
		if (in_fire) begin
			entry_s1 <= table_mem[in_idx];
		end
		if (step_fire && wr_en_d) begin
			table_mem[wr_idx_d] <= wr_entry_d;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1   <= s_tdata[2:0];
			slot_s1  <= s_tdata[3 +: SLOT_W];
			value_s1 <= s_tdata[3 + SLOT_W +: CNT_W];
		end
	end

	// stage 1 occupancy and in-use bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			slot_used_q <= '0;
		end else begin
			if (in_fire) begin
				busy_s1 <= 1'b1;
			end else if (step_fire) begin
				busy_s1 <= 1'b0;
			end
			if (step_fire && used_set_d) begin
				slot_used_q[free_idx] <= 1'b1;
			end
			if (step_fire && used_clr_d) begin
				slot_used_q[cur_idx] <= 1'b0;
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (step_fire) begin
			out_data_q <= {writable_d, readable_d, rd_d, slot_out_d, st_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TW'(out_data_q);

	// an accepted item always occupies stage 1 next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy_s1)
		else $error("accepted item not held in stage 1");

	// a stalled stage 1 keeps its command
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && !step_fire |=> busy_s1 && $stable(cmd_s1) && $stable(slot_s1))
		else $error("stalled command changed");

	// every step produces a result
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |=> m_tvalid)
		else $error("step produced no result");

	// a successful alloc marks its slot in use
	a_alloc_mark: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire && cmd_s1 == CMD_ALLOC && !pool_full |=> slot_used_q[$past(free_idx)])
		else $error("allocated slot not marked in use");

	// no new item while stage 1 is occupied
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !in_fire)
		else $error("item accepted while stage 1 busy");

endmodule
